FILE: rtl/fpp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpp_pkg
// Types and constants shared by the framed packet parser.
// ----------------------------------------------------------------------------
package fpp_pkg;

    localparam int BYTE_W    = 8;
    localparam int COUNT_W   = 3;
    localparam int STORE_N   = 4;
    localparam int IDX_W     = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [BYTE_W-1:0]    HEADER_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0]    TAIL_RESET   = 8'h55;
    localparam logic [COUNT_W-1:0]   TAIL_POS     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL     = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RECV = 2'd1,
        ST_DONE = 2'd2,
        ST_ERR  = 2'd3
    } parse_state_t;

    typedef logic [STORE_N-1:0][BYTE_W-1:0] frame_t;

    typedef struct packed {
        parse_state_t        state;
        logic [COUNT_W-1:0]  count;
        logic                store_en;
        logic [IDX_W-1:0]    store_idx;
        logic                held_en;
    } step_t;

endpackage
`default_nettype wire

FILE: rtl/fpp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fpp_step
// Next-state and store control for one received byte.
// ----------------------------------------------------------------------------
module fpp_step
    import fpp_pkg::*;
(
    input  parse_state_t        state,
    input  logic [COUNT_W-1:0]  count,
    input  logic [BYTE_W-1:0]   in_byte,
    input  logic [BYTE_W-1:0]   header,
    input  logic [BYTE_W-1:0]   tail,
    input  frame_t              store,
    output step_t               step
);

    logic               in_body;
    logic [IDX_W-1:0]   count_m1;
    logic [BYTE_W-1:0]  sum;
    logic               tail_ok;
    logic               sum_ok;

    assign in_body  = (count >= 3'd1) && (count < TAIL_POS);
    assign count_m1 = count[IDX_W-1:0] - 2'd1;
    assign sum      = store[0] + store[1] + store[2];
    assign tail_ok  = (in_byte == tail);
    assign sum_ok   = (sum == store[3]);

    always_comb begin
        step.state     = state;
        step.count     = count;
        step.store_idx = count_m1;
        step.store_en  = (state == ST_RECV) && in_body;
        step.held_en   = (state == ST_RECV) && !in_body && tail_ok;
        unique case (state)
            ST_IDLE: begin
                if (in_byte == header) begin
                    step.state = ST_RECV;
                    step.count = 3'd1;
                end
            end
            ST_RECV: begin
                if (in_body) begin
                    step.count = count + 3'd1;
                end else begin
                    step.count = '0;
                    step.state = (tail_ok && sum_ok) ? ST_DONE : ST_ERR;
                end
            end
            default: begin
                step.state = ST_IDLE;
                step.count = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/framed_packet_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// framed_packet_parser_core
// Byte-serial parser for six-byte frames with additive checksum.
// ----------------------------------------------------------------------------
// Each input beat carries one received byte and yields exactly one output
// beat, one byte per cycle unless stalled; a single result register sits
// between the state update and the master side, so the slave side keeps
// taking bytes while a result is taken in the same cycle. Frames are header,
// mode, yaw, pitch, checksum, tail; status goes on m_tuser and the payload of
// the last frame with a good tail on m_tdata. The byte after a complete or
// error status is dropped. Header and tail values are set through cfg_*.
module framed_packet_parser_core
    import fpp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [BYTE_W-1:0]     cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] in_byte
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,   // mode, yaw, pitch, sum
    output logic [1:0]                 m_tuser    // [1:0] status
);

    parse_state_t        state_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [BYTE_W-1:0]   header_reg;
    logic [BYTE_W-1:0]   tail_reg;
    frame_t              store_reg;
    frame_t              held_reg;
    frame_t              held_next;
    logic                m_valid_reg;
    logic [1:0]          status_reg;
    logic [31:0]         data_reg;
    logic                in_fire;
    step_t               step;

    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = status_reg;

    fpp_step u_step (
        .state   (state_reg),
        .count   (count_reg),
        .in_byte (s_tdata),
        .header  (header_reg),
        .tail    (tail_reg),
        .store   (store_reg),
        .step    (step)
    );

    assign held_next = step.held_en ? store_reg : held_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            header_reg  <= HEADER_RESET;
            tail_reg    <= TAIL_RESET;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_HEADER: header_reg <= cfg_wdata;
                    CFG_TAIL:   tail_reg   <= cfg_wdata;
                    default:    ;
                endcase
            end
            if (in_fire) begin
                state_reg   <= step.state;
                count_reg   <= step.count;
                held_reg    <= held_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && step.store_en) begin
            store_reg[step.store_idx] <= s_tdata;
        end
        if (in_fire) begin
            status_reg <= step.state;
            data_reg   <= held_next;
        end
    end

    a_count_recv: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RECV) == (count_reg != '0))
        else $error("byte count out of step with parse state");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= TAIL_POS)
        else $error("byte count beyond tail position");

    a_done_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == ST_DONE) |->
        (data_reg[31:24] == data_reg[7:0] + data_reg[15:8] + data_reg[23:16]))
        else $error("complete status with bad checksum");

    a_held_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_fire |=> $stable(held_reg))
        else $error("payload changed without an input beat");

endmodule
`default_nettype wire

FILE: sim/framed_packet_parser_core_test.sv
// ----------------------------------------------------------------------------
// framed_packet_parser_core_test
// Streams received bytes into the frame parser and checks every status beat.
// Uses directed frames first (extreme payload bytes, header inside a frame,
// bad tail, bad checksum, dropped byte after a verdict). Then it runs several
// header/tail settings, each with random frames, corrupt frames, noise and
// truncated frames. A byte-level parser model predicts each beat, and the
// master side is compared field by field against it. The sender idles in
// bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module framed_packet_parser_core_test;
    import fpp_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_BYTES  = 255;
    localparam int N_PHASES     = 6;

    typedef struct {
        parse_state_t           status;
        logic [3:0][BYTE_W-1:0] payload;
    } parse_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_HEADER;
    logic [BYTE_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    wire                  s_tready;
    logic [7:0]           s_tdata   = '0;
    wire                  m_tvalid;
    logic                 m_tready  = 1'b0;
    wire  [31:0]          m_tdata;
    wire  [1:0]           m_tuser;

    // parser model state
    logic [BYTE_W-1:0]      hdr_sel     = HEADER_RESET;
    logic [BYTE_W-1:0]      tail_sel    = TAIL_RESET;
    parse_state_t           frame_state = ST_IDLE;
    logic [COUNT_W-1:0]     frame_pos   = '0;
    logic [3:0][BYTE_W-1:0] frame_bytes = '0;
    logic [3:0][BYTE_W-1:0] held_bytes  = '0;

    parse_result_t  expected_status[$];
    logic [7:0]     byte_queue[$];
    int unsigned    bytes_queued = 0;
    int unsigned    bytes_taken  = 0;
    int unsigned    error_count  = 0;
    int unsigned    cycle_count  = 0;
    logic           beat_taken   = 1'b0;
    int unsigned    burst_left   = 1;
    int unsigned    gap_left     = 0;
    logic [15:0]    stall_tick   = '0;
    int unsigned    stall_mode   = 0;
    logic [7:0]     cur_hdr      = HEADER_RESET;
    logic [7:0]     cur_tail     = TAIL_RESET;

    framed_packet_parser_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 aclk = ~aclk;

    task automatic parse_byte(input logic [7:0] b);
        parse_result_t r;
        logic [7:0]    sum8;
        case (frame_state)
            ST_IDLE: begin
                if (b == hdr_sel) begin
                    frame_pos   = 3'd1;
                    frame_state = ST_RECV;
                end
            end
            ST_RECV: begin
                if (frame_pos < TAIL_POS) begin
                    frame_bytes[frame_pos - 3'd1] = b;
                    frame_pos = frame_pos + 3'd1;
                end else begin
                    frame_pos = '0;
                    if (b != tail_sel) begin
                        frame_state = ST_ERR;
                    end else begin
                        held_bytes  = frame_bytes;
                        sum8        = frame_bytes[0] + frame_bytes[1] + frame_bytes[2];
                        frame_state = (sum8 == frame_bytes[3]) ? ST_DONE : ST_ERR;
                    end
                end
            end
            default: begin
                frame_state = ST_IDLE;
                frame_pos   = '0;
            end
        endcase
        r.status  = frame_state;
        r.payload = held_bytes;
        expected_status.push_back(r);
    endtask

    function automatic void check_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
            error_count++;
        end
    endfunction

    // monitor and model update
    always @(posedge aclk) begin
        parse_result_t want;
        beat_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_status.size() == 0) begin
                    $display("%0t: unexpected beat, expected none actual status %0h data %h",
                             $time, m_tuser, m_tdata);
                    error_count++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("mode",   want.payload[0], m_tdata[7:0]);
                    check_field("yaw",    want.payload[1], m_tdata[15:8]);
                    check_field("pitch",  want.payload[2], m_tdata[23:16]);
                    check_field("sum",    want.payload[3], m_tdata[31:24]);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_HEADER: hdr_sel  = cfg_wdata;
                    CFG_TAIL:   tail_sel = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata);
                bytes_taken <= bytes_taken + 1;
            end
        end
    end

    // byte driver: bursts with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || beat_taken) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (byte_queue.size() != 0) begin
                s_tdata  <= byte_queue.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 48);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: stall pattern switches whenever the low byte of stall_tick wraps to zero
    always @(negedge aclk) begin
        stall_tick <= stall_tick + 1'b1;
        if (stall_tick[7:0] == 8'd0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (stall_tick[3:0] < 4'd11);
            default: m_tready <= ($urandom_range(0, 1) != 0);
        endcase
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        byte_queue.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_frame(input logic [7:0] mode_b, input logic [7:0] yaw_b,
                              input logic [7:0] pitch_b, input logic [7:0] sum_b,
                              input logic [7:0] tail_b);
        queue_byte(cur_hdr);
        queue_byte(mode_b);
        queue_byte(yaw_b);
        queue_byte(pitch_b);
        queue_byte(sum_b);
        queue_byte(tail_b);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return cur_hdr;
            3:       return cur_tail;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic queue_random_traffic(input int unsigned n);
        int unsigned made;
        int unsigned kind;
        int unsigned k;
        logic [7:0]  mode_b, yaw_b, pitch_b, sum_b;
        made = 0;
        while (made < n) begin
            kind    = $urandom_range(0, 15);
            mode_b  = rand_byte();
            yaw_b   = rand_byte();
            pitch_b = rand_byte();
            sum_b   = mode_b + yaw_b + pitch_b;
            if (kind < 13) begin
                if (kind < 10) begin
                    push_frame(mode_b, yaw_b, pitch_b, sum_b, cur_tail);
                end else if (kind < 12) begin
                    push_frame(mode_b, yaw_b, pitch_b,
                               sum_b ^ 8'($urandom_range(1, 255)), cur_tail);
                end else begin
                    push_frame(mode_b, yaw_b, pitch_b, sum_b,
                               cur_tail ^ 8'($urandom_range(1, 255)));
                end
                // byte after the verdict, dropped
                queue_byte(($urandom_range(0, 3) == 0) ? cur_hdr : rand_byte());
                made += 7;
            end else if (kind < 15) begin
                k = $urandom_range(1, 4);
                repeat (k) queue_byte(rand_byte());
                made += k;
            end else begin
                k = $urandom_range(0, 4);
                queue_byte(cur_hdr);
                repeat (k) queue_byte(rand_byte());
                made += k + 1;
            end
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (bytes_taken != bytes_queued || expected_status.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [7:0] hdr_list[N_PHASES];
        logic [7:0] tail_list[N_PHASES];
        hdr_list  = '{HEADER_RESET, 8'h00, 8'hFF, 8'h5A, 8'h00, 8'h00};
        tail_list = '{TAIL_RESET,   8'hFF, 8'h00, 8'h5A, 8'h00, 8'h00};
        hdr_list[4]  = 8'($urandom_range(0, 255));
        tail_list[4] = 8'($urandom_range(0, 255));
        hdr_list[5]  = 8'($urandom_range(0, 255));
        tail_list[5] = 8'($urandom_range(0, 255));

        // idle noise, then a good frame with the header value as data and a
        // wrapping sum, a bad tail, a bad checksum; each verdict eats one byte
        queue_byte(8'h00);
        queue_byte(8'hFF);
        push_frame(HEADER_RESET, 8'hFF, 8'h57, 8'h00, TAIL_RESET);
        queue_byte(HEADER_RESET);
        push_frame(8'h01, 8'h02, 8'h03, 8'h06, 8'h00);
        queue_byte(TAIL_RESET);
        push_frame(8'h10, 8'h20, 8'h30, 8'h00, TAIL_RESET);
        queue_byte(8'h7F);

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph != 0) begin
                wait_drained();
                cur_hdr  = hdr_list[ph];
                cur_tail = tail_list[ph];
                write_reg(CFG_HEADER, cur_hdr);
                write_reg(CFG_TAIL, cur_tail);
            end
            queue_random_traffic(PHASE_BYTES);
        end

        wait_drained();
        repeat (8) @(negedge aclk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
